>>> hw/rtl/lapt_pkg.sv
// Shared types, constants and helper functions for the lever-arm position transform.
package lapt_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int POS_BITS_DEF   = 32;
  localparam int CORDIC_STEPS   = 16;
  localparam int TRIG_W         = 18;
  localparam int Q15_W          = 16;
  localparam int PAIR_W         = 32;
  localparam int TRI_W          = 33;
  localparam int ENTRY_W        = 34;
  localparam int ARM_W          = 16;
  localparam int PROD_W         = ENTRY_W + ARM_W;
  localparam int SUM_W          = PROD_W + 2;
  localparam int D_W            = SUM_W - 30;
  localparam int LANES          = 3;
  localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 18'sd19898;

  typedef enum logic [1:0] {
    REG_FORWARD   = 2'd0,
    REG_STARBOARD = 2'd1,
    REG_DOWN      = 2'd2,
    REG_NONE      = 2'd3
  } cfg_reg_t;

  typedef logic signed [Q15_W-1:0]   q15_t;
  typedef logic signed [ENTRY_W-1:0] entry_t;

  typedef struct packed {
    logic                     neg;
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
    logic signed [TRIG_W-1:0] z;
  } trig_lane_t;

  // Row-major rotation matrix, Q4.30.
  typedef struct packed {
    entry_t r00; entry_t r01; entry_t r02;
    entry_t r10; entry_t r11; entry_t r12;
    entry_t r20; entry_t r21; entry_t r22;
  } mat_t;

  typedef struct packed {
    logic signed [ARM_W-1:0] fwd;
    logic signed [ARM_W-1:0] stbd;
    logic signed [ARM_W-1:0] down;
  } arm_t;

  function automatic logic signed [TRIG_W-1:0] atan_step(input int step);
    case (step)
      0:  atan_step = 18'sd8192;
      1:  atan_step = 18'sd4836;
      2:  atan_step = 18'sd2555;
      3:  atan_step = 18'sd1297;
      4:  atan_step = 18'sd651;
      5:  atan_step = 18'sd326;
      6:  atan_step = 18'sd163;
      7:  atan_step = 18'sd81;
      8:  atan_step = 18'sd41;
      9:  atan_step = 18'sd20;
      10: atan_step = 18'sd10;
      11: atan_step = 18'sd5;
      12: atan_step = 18'sd3;
      13: atan_step = 18'sd1;
      14: atan_step = 18'sd1;
      default: atan_step = 18'sd0;
    endcase
  endfunction

  // Undo the half-turn fold and clamp to the symmetric Q1.15 range.
  function automatic q15_t finish_q15(input logic signed [TRIG_W-1:0] v, input logic neg);
    logic signed [TRIG_W-1:0] n;
    n = neg ? -v : v;
    if (n > 18'sd32767) finish_q15 = 16'sd32767;
    else if (n < -18'sd32767) finish_q15 = -16'sd32767;
    else finish_q15 = n[Q15_W-1:0];
  endfunction

endpackage

>>> hw/rtl/lapt_cordic_cell.sv
// One CORDIC rotation step for the roll, pitch and yaw lanes, registered.
module lapt_cordic_cell #(
  parameter int STEP   = 0,
  parameter int SIDE_W = 1
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        en,
  input  logic                                        in_vld,
  input  lapt_pkg::trig_lane_t [lapt_pkg::LANES-1:0]  in_lanes,
  input  logic [SIDE_W-1:0]                           in_side,
  output logic                                        out_vld,
  output lapt_pkg::trig_lane_t [lapt_pkg::LANES-1:0]  out_lanes,
  output logic [SIDE_W-1:0]                           out_side
);

  localparam logic signed [lapt_pkg::TRIG_W-1:0] ATAN = lapt_pkg::atan_step(STEP);

  lapt_pkg::trig_lane_t [lapt_pkg::LANES-1:0] lanes_next;

  always_comb begin
    logic signed [lapt_pkg::TRIG_W-1:0] xs;
    logic signed [lapt_pkg::TRIG_W-1:0] ys;
    for (int l = 0; l < lapt_pkg::LANES; l++) begin
      xs = in_lanes[l].x >>> STEP;
      ys = in_lanes[l].y >>> STEP;
      lanes_next[l].neg = in_lanes[l].neg;
      if (!in_lanes[l].z[lapt_pkg::TRIG_W-1]) begin
        lanes_next[l].x = in_lanes[l].x - ys;
        lanes_next[l].y = in_lanes[l].y + xs;
        lanes_next[l].z = in_lanes[l].z - ATAN;
      end else begin
        lanes_next[l].x = in_lanes[l].x + ys;
        lanes_next[l].y = in_lanes[l].y - xs;
        lanes_next[l].z = in_lanes[l].z + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_lanes <= lanes_next;
      out_side  <= in_side;
    end
  end

endmodule

>>> hw/rtl/lapt_matrix.sv
// Builds the body-to-NED rotation matrix from the CORDIC outputs over four stages.
module lapt_matrix #(
  parameter int SIDE_W = 1
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        en,
  input  logic                                        in_vld,
  input  lapt_pkg::trig_lane_t [lapt_pkg::LANES-1:0]  in_lanes,
  input  logic [SIDE_W-1:0]                           in_side,
  output logic                                        out_vld,
  output lapt_pkg::mat_t                              out_mat,
  output logic [SIDE_W-1:0]                           out_side
);

  localparam int PW = lapt_pkg::PAIR_W;
  localparam int TW = lapt_pkg::TRI_W;
  localparam int EW = lapt_pkg::ENTRY_W;

  logic [2:0]          vld;
  logic [SIDE_W-1:0]   side [3];

  // Stage T: final sine/cosine.
  lapt_pkg::q15_t sr, cr, sp, cp, sy, cy;
  // Stage M1: pairwise products.
  logic signed [PW-1:0] p_cysp, p_srsp, p_spsy;
  logic signed [PW-1:0] p_cycp, p_sycr, p_sysr, p_sycp, p_cycr, p_cysr, p_cpsr, p_cpcr;
  lapt_pkg::q15_t sr1, cr1, sy1, sp1;
  // Stage M2: rounded triple products, exact pairs carried along.
  logic signed [TW-1:0] t1, t2, t3, t4;
  logic signed [PW-1:0] e_cycp, e_sycr, e_sysr, e_sycp, e_cycr, e_cysr, e_cpsr, e_cpcr;
  lapt_pkg::q15_t sp2;

  logic signed [2*PW-1:0] x1, x2, x3, x4;
  logic signed [TW-1:0]   t1_next, t2_next, t3_next, t4_next;

  function automatic logic signed [TW-1:0] rnd15(input logic signed [2*PW-1:0] v);
    logic signed [2*PW-1:0] a;
    a = v + (2*PW)'(16384);
    rnd15 = a[TW+14:15];
  endfunction

  always_comb begin
    x1 = (2*PW)'(p_cysp * sr1);
    x2 = (2*PW)'(p_cysp * cr1);
    x3 = (2*PW)'(p_srsp * sy1);
    x4 = (2*PW)'(p_spsy * cr1);
    t1_next = rnd15(x1);
    t2_next = rnd15(x2);
    t3_next = rnd15(x3);
    t4_next = rnd15(x4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld     <= {vld[1:0], in_vld};
      out_vld <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sr <= lapt_pkg::finish_q15(in_lanes[0].y, in_lanes[0].neg);
      cr <= lapt_pkg::finish_q15(in_lanes[0].x, in_lanes[0].neg);
      sp <= lapt_pkg::finish_q15(in_lanes[1].y, in_lanes[1].neg);
      cp <= lapt_pkg::finish_q15(in_lanes[1].x, in_lanes[1].neg);
      sy <= lapt_pkg::finish_q15(in_lanes[2].y, in_lanes[2].neg);
      cy <= lapt_pkg::finish_q15(in_lanes[2].x, in_lanes[2].neg);
      side[0] <= in_side;

      p_cysp <= cy * sp;  p_srsp <= sr * sp;  p_spsy <= sp * sy;
      p_cycp <= cy * cp;  p_sycr <= sy * cr;  p_sysr <= sy * sr;
      p_sycp <= sy * cp;  p_cycr <= cy * cr;  p_cysr <= cy * sr;
      p_cpsr <= cp * sr;  p_cpcr <= cp * cr;
      sr1 <= sr; cr1 <= cr; sy1 <= sy; sp1 <= sp;
      side[1] <= side[0];

      t1 <= t1_next; t2 <= t2_next; t3 <= t3_next; t4 <= t4_next;
      e_cycp <= p_cycp; e_sycr <= p_sycr; e_sysr <= p_sysr; e_sycp <= p_sycp;
      e_cycr <= p_cycr; e_cysr <= p_cysr; e_cpsr <= p_cpsr; e_cpcr <= p_cpcr;
      sp2 <= sp1;
      side[2] <= side[1];

      out_mat.r00 <= EW'(e_cycp);
      out_mat.r01 <= EW'(t1) - EW'(e_sycr);
      out_mat.r02 <= EW'(t2) + EW'(e_sysr);
      out_mat.r10 <= EW'(e_sycp);
      out_mat.r11 <= EW'(t3) + EW'(e_cycr);
      out_mat.r12 <= EW'(t4) - EW'(e_cysr);
      out_mat.r20 <= -(EW'(sp2) <<< 15);
      out_mat.r21 <= EW'(e_cpsr);
      out_mat.r22 <= EW'(e_cpcr);
      out_side    <= side[2];
    end
  end

endmodule

>>> hw/rtl/lapt_rotate.sv
// Rotates the lever arm by the matrix, applies it to the position and saturates.
module lapt_rotate #(
  parameter int POS_BITS = lapt_pkg::POS_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_vld,
  input  lapt_pkg::mat_t            in_mat,
  input  lapt_pkg::arm_t            arm,
  input  logic [3*POS_BITS:0]       in_side,
  output logic                      out_vld,
  output logic signed [POS_BITS-1:0] res_north,
  output logic signed [POS_BITS-1:0] res_east,
  output logic signed [POS_BITS-1:0] res_down,
  output logic                      res_sat
);

  localparam int PRW = lapt_pkg::PROD_W;
  localparam int SW  = lapt_pkg::SUM_W;
  localparam int DW  = lapt_pkg::D_W;
  localparam int RW  = POS_BITS + 1;
  localparam int SIDE_W = 3*POS_BITS + 1;

  logic [1:0]                 vld;
  logic [SIDE_W-1:0]          side1, side2;
  logic signed [PRW-1:0]      prod [3][3];
  logic signed [DW-1:0]       d [3];
  logic signed [DW-1:0]       d_next [3];
  logic signed [POS_BITS-1:0] pos [3];
  logic signed [POS_BITS-1:0] res_next [3];
  logic [2:0]                 sat_next;
  lapt_pkg::entry_t           ent [3][3];

  assign ent[0][0] = in_mat.r00; assign ent[0][1] = in_mat.r01; assign ent[0][2] = in_mat.r02;
  assign ent[1][0] = in_mat.r10; assign ent[1][1] = in_mat.r11; assign ent[1][2] = in_mat.r12;
  assign ent[2][0] = in_mat.r20; assign ent[2][1] = in_mat.r21; assign ent[2][2] = in_mat.r22;

  assign pos[0] = side2[3*POS_BITS-1:2*POS_BITS];
  assign pos[1] = side2[2*POS_BITS-1:POS_BITS];
  assign pos[2] = side2[POS_BITS-1:0];

  always_comb begin
    logic signed [SW-1:0] s;
    for (int j = 0; j < 3; j++) begin
      s = SW'(prod[j][0]) + SW'(prod[j][1]) + SW'(prod[j][2]) + SW'(64'sd536870912);
      d_next[j] = s[SW-1:30];
    end
  end

  always_comb begin
    logic signed [RW-1:0] r;
    for (int j = 0; j < 3; j++) begin
      r = side2[3*POS_BITS] ? RW'(pos[j]) - RW'(d[j]) : RW'(pos[j]) + RW'(d[j]);
      sat_next[j] = r[RW-1] != r[RW-2];
      if (!sat_next[j]) res_next[j] = r[POS_BITS-1:0];
      else if (r[RW-1]) res_next[j] = {1'b1, {(POS_BITS-1){1'b0}}};
      else res_next[j] = {1'b0, {(POS_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld     <= {vld[0], in_vld};
      out_vld <= vld[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        prod[j][0] <= ent[j][0] * arm.fwd;
        prod[j][1] <= ent[j][1] * arm.stbd;
        prod[j][2] <= ent[j][2] * arm.down;
        d[j]       <= d_next[j];
      end
      side1     <= in_side;
      side2     <= side1;
      res_north <= res_next[0];
      res_east  <= res_next[1];
      res_down  <= res_next[2];
      res_sat   <= |sat_next;
    end
  end

endmodule

>>> hw/rtl/lever_arm_position_transform_top.sv
// Pipeline: 16 CORDIC cells, 4 matrix stages and 3 rotate stages from request acceptance to result.
// Throughput: one request per cycle; the whole chain advances together and holds only
//   while a finished result sits in the output register with out_stall high.
// Reset (rst, synchronous, active high) clears all stage valid bits and the lever arm
//   registers to zero; payload registers are not reset.
// Configuration is taken every cycle (cfg_ready is tied high).
module lever_arm_position_transform_top #(
  parameter int ANGLE_BITS = lapt_pkg::ANGLE_BITS_DEF,
  parameter int POS_BITS   = lapt_pkg::POS_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       mode,
  input  logic signed [POS_BITS-1:0] pos_north,
  input  logic signed [POS_BITS-1:0] pos_east,
  input  logic signed [POS_BITS-1:0] pos_down,
  input  logic signed [ANGLE_BITS-1:0] roll,
  input  logic signed [ANGLE_BITS-1:0] pitch,
  input  logic signed [ANGLE_BITS-1:0] yaw,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [POS_BITS-1:0] out_north,
  output logic signed [POS_BITS-1:0] out_east,
  output logic signed [POS_BITS-1:0] out_down,
  output logic                       saturated,
  // configuration write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [15:0]                cfg_data
);

  localparam int SIDE_W = 3*POS_BITS + 1;
  localparam int STEPS  = lapt_pkg::CORDIC_STEPS;
  localparam int TW     = lapt_pkg::TRIG_W;

  // Advance the whole chain unless the output register holds an untaken result.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign cfg_ready = 1'b1;

  // Lever arm registers.
  lapt_pkg::arm_t arm;

  always_ff @(posedge clk) begin
    if (rst) begin
      arm <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (lapt_pkg::cfg_reg_t'(cfg_index))
        lapt_pkg::REG_FORWARD:   arm.fwd  <= cfg_data;
        lapt_pkg::REG_STARBOARD: arm.stbd <= cfg_data;
        lapt_pkg::REG_DOWN:      arm.down <= cfg_data;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  // Bring each angle to 16 bits per turn, then fold into the CORDIC's half-turn range.
  logic signed [15:0] ang16 [3];
  logic signed [ANGLE_BITS-1:0] ang_raw [3];
  assign ang_raw[0] = roll;
  assign ang_raw[1] = pitch;
  assign ang_raw[2] = yaw;

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_ang
      if (ANGLE_BITS >= 16) begin : g_trunc
        assign ang16[g] = ang_raw[g][ANGLE_BITS-1 -: 16];
      end else begin : g_pad
        assign ang16[g] = {ang_raw[g], {(16-ANGLE_BITS){1'b0}}};
      end
    end
  endgenerate

  lapt_pkg::trig_lane_t [lapt_pkg::LANES-1:0] lanes_c [STEPS+1];
  logic                                       vld_c   [STEPS+1];
  logic [SIDE_W-1:0]                          side_c  [STEPS+1];

  always_comb begin
    logic signed [TW-1:0] z;
    for (int l = 0; l < lapt_pkg::LANES; l++) begin
      z = TW'(ang16[l]);
      lanes_c[0][l].x   = lapt_pkg::CORDIC_X0;
      lanes_c[0][l].y   = '0;
      lanes_c[0][l].neg = 1'b0;
      if (z > 18'sd16384) begin
        z = z - 18'sd32768;
        lanes_c[0][l].neg = 1'b1;
      end else if (z < -18'sd16384) begin
        z = z + 18'sd32768;
        lanes_c[0][l].neg = 1'b1;
      end
      lanes_c[0][l].z = z;
    end
  end

  assign vld_c[0]  = in_valid;
  assign side_c[0] = {mode, pos_north, pos_east, pos_down};

  // CORDIC chain: one cell per step, all three angles side by side.
  generate
    for (g = 0; g < STEPS; g++) begin : g_cell
      lapt_cordic_cell #(
        .STEP   (g),
        .SIDE_W (SIDE_W)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .en        (en),
        .in_vld    (vld_c[g]),
        .in_lanes  (lanes_c[g]),
        .in_side   (side_c[g]),
        .out_vld   (vld_c[g+1]),
        .out_lanes (lanes_c[g+1]),
        .out_side  (side_c[g+1])
      );
    end
  endgenerate

  logic              mat_vld;
  lapt_pkg::mat_t    mat;
  logic [SIDE_W-1:0] mat_side;

  lapt_matrix #(
    .SIDE_W (SIDE_W)
  ) u_matrix (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (vld_c[STEPS]),
    .in_lanes (lanes_c[STEPS]),
    .in_side  (side_c[STEPS]),
    .out_vld  (mat_vld),
    .out_mat  (mat),
    .out_side (mat_side)
  );

  // Last stage of the rotate unit is the output register.
  lapt_rotate #(
    .POS_BITS (POS_BITS)
  ) u_rotate (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (mat_vld),
    .in_mat    (mat),
    .arm       (arm),
    .in_side   (mat_side),
    .out_vld   (out_valid),
    .res_north (out_north),
    .res_east  (out_east),
    .res_down  (out_down),
    .res_sat   (saturated)
  );

`ifndef SYNTHESIS
  localparam logic signed [POS_BITS-1:0] PMAX = {1'b0, {(POS_BITS-1){1'b1}}};
  localparam logic signed [POS_BITS-1:0] PMIN = {1'b1, {(POS_BITS-1){1'b0}}};

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("request stalled with empty output register");

  a_sat_clamps: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      (out_north == PMAX || out_north == PMIN || out_east == PMAX ||
       out_east == PMIN || out_down == PMAX || out_down == PMIN))
    else $error("saturation flag without a clamped component");

  a_cfg_forward: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index == lapt_pkg::REG_FORWARD |=>
      arm.fwd == $past(cfg_data))
    else $error("forward arm write lost");

  a_chain_hold: assert property (@(posedge clk) disable iff (rst)
    !en && mat_vld |=> mat_vld)
    else $error("matrix stage dropped a request during hold");
`endif

endmodule

>>> bench/lever_arm_checker.sv
// Checker: predicts each lever-arm transform result and compares it with the block output.
module lever_arm_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               mode,
  input  logic signed [31:0] pos_north,
  input  logic signed [31:0] pos_east,
  input  logic signed [31:0] pos_down,
  input  logic signed [15:0] roll,
  input  logic signed [15:0] pitch,
  input  logic signed [15:0] yaw,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_north,
  input  logic signed [31:0] out_east,
  input  logic signed [31:0] out_down,
  input  logic               saturated,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] north;
    logic signed [31:0] east;
    logic signed [31:0] down;
    logic               sat;
  } fix_t;

  fix_t fix_q[$];
  logic signed [15:0] lever[3];

  // Floor shift, same as >>> on signed longint.
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic void trig(input longint a, output longint s, output longint c);
    longint x, y, z, t;
    logic flip;
    int tab[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
    x = 19898; y = 0; z = a; flip = 0;
    if (z > 16384) begin z -= 32768; flip = 1; end
    else if (z < -16384) begin z += 32768; flip = 1; end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        t = x - floor_shr(y, i); y = y + floor_shr(x, i); z -= tab[i];
      end else begin
        t = x + floor_shr(y, i); y = y - floor_shr(x, i); z += tab[i];
      end
      x = t;
    end
    if (flip) begin x = -x; y = -y; end
    if (x > 32767) x = 32767;
    if (x < -32767) x = -32767;
    if (y > 32767) y = 32767;
    if (y < -32767) y = -32767;
    c = x; s = y;
  endfunction

  function automatic longint tri3(longint a, longint b, longint c);
    return floor_shr(a * b * c + (64'sd1 <<< 14), 15);
  endfunction

  function automatic fix_t transform(logic m, longint pn, longint pe, longint pd,
                                     longint ro, longint pi, longint ya);
    longint sr, cr, sp, cp, sy, cy, d, res;
    longint rm[3][3];
    longint p[3];
    longint arm[3];
    longint r[3];
    fix_t f;
    trig(ro, sr, cr); trig(pi, sp, cp); trig(ya, sy, cy);
    rm[0][0] = cy * cp;
    rm[0][1] = -sy * cr + tri3(cy, sp, sr);
    rm[0][2] = sy * sr + tri3(cy, cr, sp);
    rm[1][0] = sy * cp;
    rm[1][1] = cy * cr + tri3(sr, sp, sy);
    rm[1][2] = -cy * sr + tri3(sp, sy, cr);
    rm[2][0] = -sp * 32768;
    rm[2][1] = cp * sr;
    rm[2][2] = cp * cr;
    p[0] = pn; p[1] = pe; p[2] = pd;
    for (int k = 0; k < 3; k++) arm[k] = lever[k];
    f.sat = 0;
    for (int j = 0; j < 3; j++) begin
      d = floor_shr(rm[j][0] * arm[0] + rm[j][1] * arm[1] + rm[j][2] * arm[2]
                    + (64'sd1 <<< 29), 30);
      res = m ? p[j] - d : p[j] + d;
      if (res > 64'sd2147483647) begin res = 64'sd2147483647; f.sat = 1; end
      if (res < -64'sd2147483648) begin res = -64'sd2147483648; f.sat = 1; end
      r[j] = res;
    end
    f.north = r[0][31:0]; f.east = r[1][31:0]; f.down = r[2][31:0];
    return f;
  endfunction

  assign pending = fix_q.size();

  always @(posedge clk) begin
    fix_t e;
    if (rst) begin
      lever[0] <= '0; lever[1] <= '0; lever[2] <= '0;
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (lapt_pkg::cfg_reg_t'(cfg_index))
          lapt_pkg::REG_FORWARD:   lever[0] <= cfg_data;
          lapt_pkg::REG_STARBOARD: lever[1] <= cfg_data;
          lapt_pkg::REG_DOWN:      lever[2] <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        fix_q.push_back(transform(mode, pos_north, pos_east, pos_down, roll, pitch, yaw));
      if (out_valid && !out_stall) begin
        if (fix_q.size() == 0) begin
          $display("%t unexpected result got %h %h %h %b", $time,
                   out_north, out_east, out_down, saturated);
          fail_count <= fail_count + 1;
        end else begin
          e = fix_q.pop_front();
          if (e.north !== out_north || e.east !== out_east || e.down !== out_down ||
              e.sat !== saturated) begin
            $display("%t mismatch expected %h %h %h %b actual %h %h %h %b", $time,
                     e.north, e.east, e.down, e.sat, out_north, out_east, out_down,
                     saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

>>> bench/testbench.sv
// Top of the lever-arm transform bench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, in_stall;
  logic mode = 0;
  logic signed [31:0] pos_north = 0, pos_east = 0, pos_down = 0;
  logic signed [15:0] roll = 0, pitch = 0, yaw = 0;
  logic out_valid, out_stall = 0;
  logic signed [31:0] out_north, out_east, out_down;
  logic saturated;
  logic cfg_valid = 0, cfg_ready;
  logic [1:0] cfg_index = 0;
  logic [15:0] cfg_data = 0;
  int fail_count, pending;
  int idle_pct = 15;   // random idle share for both sides
  bit hold_off = 0;    // receiver pressure stretch
  int quiet = 0;

  always #4 clk = ~clk;

  lever_arm_position_transform_top dut (.*);
  lever_arm_checker chk (.*);

  // Receiver: random stalls, or a long hold-off while hold_off is set.
  always @(negedge clk) begin
    if (rst) out_stall <= 0;
    else out_stall <= hold_off || ($urandom_range(99) < idle_pct);
  end

  // Watchdog: count cycles where nothing moves on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one request and hold it until the block takes it.
  task automatic send(logic m, logic [31:0] n, logic [31:0] e, logic [31:0] d,
                      logic [15:0] r, logic [15:0] p, logic [15:0] y);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; mode <= m;
    pos_north <= n; pos_east <= e; pos_down <= d;
    roll <= r; pitch <= p; yaw <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic set_arm(logic [15:0] f, logic [15:0] s, logic [15:0] d);
    logic [15:0] v[3];
    v[0] = f; v[1] = s; v[2] = d;
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1; cfg_index <= i[1:0];
      cfg_data <= (i == int'(lapt_pkg::REG_NONE)) ? 16'hffff : v[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 0;
  endtask

  // Skew toward extremes now and then so saturation is reached.
  function automatic logic [31:0] rand_pos();
    case ($urandom_range(5))
      0: return 32'h7fffff00 + $urandom_range(255);
      1: return 32'h80000000 + $urandom_range(255);
      2: return $urandom_range(65535) - 32768;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(5))
      0: return 16'(16'h4000 + $urandom_range(7) - 4);
      1: return 16'(16'hc000 + $urandom_range(7) - 4);
      2: return 16'(16'h8000 + $urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] corner[7];
    corner = '{16'h0000, 16'h4000, 16'hc000, 16'h8000, 16'h7fff, 16'h4001, 16'hbfff};
    repeat (2) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // Directed: zero arm, then extreme arms with corner angles and positions.
    send(0, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0);
    send(1, 32'h80000000, 32'h7fffffff, 32'hffffffff, 16'h7fff, 16'h8000, 16'h4000);
    drain();
    set_arm(16'h7fff, 16'h8000, 16'h7fff);
    for (int i = 0; i < 7; i++)
      send(i[0], 32'h7fffffff, 32'h80000000, 32'h00001234, corner[i], corner[(i+2)%7],
           corner[(i+4)%7]);
    send(0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0);
    send(1, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0);
    drain();
    set_arm(16'h8000, 16'h8000, 16'h8000);
    for (int i = 0; i < 7; i++)
      send(~i[0], 32'h80000000, 32'h7fffffff, 0, corner[(i+3)%7], corner[i], corner[(i+1)%7]);
    drain();
    // Random phases with fresh arm settings.
    for (int ph = 0; ph < 6; ph++) begin
      set_arm(16'($urandom), 16'($urandom), 16'($urandom));
      idle_pct = (ph == 2) ? 0 : 15;
      for (int k = 0; k < 320; k++) begin
        if (ph == 3 && k == 40) begin
          // Hold the receiver off long enough to fill the pipeline.
          fork
            begin
              hold_off = 1;
              repeat (80) @(negedge clk);
              hold_off = 0;
            end
          join_none
        end
        send(1'($urandom_range(1)), rand_pos(), rand_pos(), rand_pos(),
             rand_angle(), rand_angle(), rand_angle());
      end
      drain();
    end
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

>>> files.f
hw/rtl/lapt_pkg.sv
hw/rtl/lapt_cordic_cell.sv
hw/rtl/lapt_matrix.sv
hw/rtl/lapt_rotate.sv
hw/rtl/lever_arm_position_transform_top.sv
bench/lever_arm_checker.sv
bench/testbench.sv
